[hdl/bfwsc_pkg.sv]
// ----------------------------------------------------------------------------
// bfwsc_pkg - shared types and constants of the ball follow speed controller
// field widths, fixed-point formats, fixed commands and saturation helpers
// ----------------------------------------------------------------------------
package bfwsc_pkg;

	localparam int POS_BITS  = 12;
	localparam int AREA_BITS = 24;

	localparam int CFG_W   = 10;
	localparam int THR_W   = 16;
	localparam int SB_W    = 9;
	localparam int DEC_W   = 16;
	localparam int SS_W    = 17;
	localparam int SPD_W   = 10;
	localparam int HOLD_W  = 10;
	localparam int DIST_W  = 18;
	localparam int SQ_W    = 2 * DIST_W;
	localparam int DIV_NW  = SQ_W;
	localparam int DIV_DW  = AREA_BITS;
	localparam int OFF_W   = POS_BITS + 18;
	localparam int TRN_W   = OFF_W + CFG_W + 1;
	localparam int ACC_W   = OFF_W + CFG_W + 2;
	localparam int SUM_W   = SB_W + 2;

	localparam int IN_RAW_W  = 2 + 2 * POS_BITS + AREA_BITS;
	localparam int IN_DATA_W = ((IN_RAW_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = 32;

	localparam int CFG_IDX_W = 3;

	localparam logic signed [SPD_W-1:0] SPD_LIMIT = 10'sd500;
	localparam logic signed [SPD_W-1:0] BACK_SPD  = -10'sd250;
	localparam logic signed [SPD_W-1:0] SPIN_SPD  = 10'sd200;
	localparam logic signed [SPD_W-1:0] REACQ_SPD = 10'sd150;
	localparam logic [HOLD_W-1:0] BACK_HOLD  = 10'd40;
	localparam logic [HOLD_W-1:0] SPIN_HOLD  = 10'd80;
	localparam logic [HOLD_W-1:0] REACQ_HOLD = 10'd400;
	localparam logic [SUM_W-1:0]  SEARCH_EXTRA = 11'd10;
	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TURN_GAIN, REG_FORWARD_GAIN, REG_DISTANCE_SCALE, REG_STOP_DISTANCE,
		REG_TURN_DISTANCE, REG_SEARCH_BASE, REG_SEARCH_START, REG_SEARCH_DECAY
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_DIV, ST_ROOT, ST_MULT, ST_SUM, ST_EMIT_PRE, ST_EMIT_FIN
	} state_t;

	typedef struct packed {
		logic [SPD_W-1:0]  left_speed;
		logic [SPD_W-1:0]  right_speed;
		logic [HOLD_W-1:0] hold_ms;
		logic              tracking;
		logic              last_of_run;
	} res_t;

	// truncate toward zero after dropping 16 fraction bits, then clamp
	function automatic logic [SPD_W-1:0] div_sat(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] q;
		q = v >>> 16;
		if (v < 0 && v[15:0] != 16'd0)
			q = q + ACC_W'(1);
		if (q > ACC_W'(SPD_LIMIT))
			q = ACC_W'(SPD_LIMIT);
		else if (q < -ACC_W'(SPD_LIMIT))
			q = -ACC_W'(SPD_LIMIT);
		return q[SPD_W-1:0];
	endfunction

	function automatic logic [SPD_W-1:0] sat_u(input logic [SUM_W-1:0] a);
		if (a > SUM_W'(SPD_LIMIT))
			return SPD_LIMIT;
		return a[SPD_W-1:0];
	endfunction

endpackage

[hdl/ball_follow_wheel_speed_controller.sv]
// ----------------------------------------------------------------------------
// ball_follow_wheel_speed_controller - wheel commands from vision frame results
// one frame result in, one or two wheel drive commands out
// ----------------------------------------------------------------------------
// usage
// - s_* takes one frame result per transfer: bump, ball_seen, ball_x,
//   blob_area, frame_width packed in s_tdata
// - m_* gives wheel commands: speeds and hold time in m_tdata, the tracking
//   flag in m_tuser, tlast on the final command of a frame
// - cfg_wr/cfg_index/cfg_data write the gain, threshold and search registers;
//   write them only while no frame is in flight
// timing
// - one frame at a time; s_tready is low from the transfer until the last
//   command has been loaded into the output register
// - bump frames: the first command is loaded from the EMIT_PRE state and the
//   second from EMIT_FIN; lost-ball frames load their one command from EMIT_FIN
// - seen frames: the last command follows the serial divide (area and offset
//   run side by side), the serial square root, the MULT and SUM states for
//   products and sums and the EMIT states for the hand-over
// - the next frame can be taken while the last command still waits in the
//   output register
// reset clears the registers to their defaults, forgets the ball and loads
// the search speed from the default search_start; a stalled m_tready simply
// holds the command and the frame engine waits for the output register to free up
// ----------------------------------------------------------------------------
module ball_follow_wheel_speed_controller (
	input  logic                                clk,
	input  logic                                arst_n,
	// bump, ball_seen, ball_x, blob_area, frame_width from bit 0 up
	input  logic [bfwsc_pkg::IN_DATA_W-1:0]     s_tdata,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// left_speed, right_speed, hold_ms from bit 0 up
	output logic [bfwsc_pkg::OUT_DATA_W-1:0]    m_tdata,
	// tracking
	output logic                                m_tuser,
	output logic                                m_tlast,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	input  logic                                cfg_wr,
	input  logic [bfwsc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bfwsc_pkg::THR_W-1:0]         cfg_data
);
	import bfwsc_pkg::*;

	// configuration registers
	logic [CFG_W-1:0] turn_gain_q, forward_gain_q, distance_scale_q;
	logic [THR_W-1:0] stop_distance_q, turn_distance_q;
	logic [SB_W-1:0]  search_base_q, search_start_q;
	logic [DEC_W-1:0] search_decay_q;

	// frame state
	logic             tracked_q;
	logic [SS_W-1:0]  ss_q;
	logic [SS_W+DEC_W-1:0] ss_prod;

	// input fields
	logic                 in_bump, in_seen;
	logic [POS_BITS-1:0]  in_x, in_w;
	logic [AREA_BITS-1:0] in_area;
	logic                 s_xfer;

	// pipeline of the seen-frame arithmetic
	state_t state_q, state_d;
	logic area_zero_q, width_zero_q, off_neg_q;
	logic signed [OFF_W-1:0] off_q;
	logic [DIST_W-1:0]       d_q;
	logic signed [TRN_W-1:0] trn_q;
	logic [CFG_W+DIST_W-1:0] fwd_q;

	// result slots and output register
	res_t pre_q, fin_q, out_q;
	logic pre_vld_q, out_vld_q;
	logic slot_free, load_pre, load_fin, div_start;

	// divider and square root
	logic [2*CFG_W-1:0] ds_sq;
	logic [DIV_NW-1:0]  dist_num, off_num, dist_quot, off_quot;
	logic [POS_BITS:0]  x2, off_mag;
	logic               dist_done, off_done, root_done;
	logic [DIST_W-1:0]  root;
	logic [POS_BITS+16:0] off_q_mag;

	// drive arithmetic
	logic signed [ACC_W-1:0] fwd_e, trn_e;
	logic [SPD_W-1:0] l_calc, r_calc;

	assign in_bump = s_tdata[0];
	assign in_seen = s_tdata[1];
	assign in_x    = s_tdata[2 +: POS_BITS];
	assign in_area = s_tdata[2 + POS_BITS +: AREA_BITS];
	assign in_w    = s_tdata[2 + POS_BITS + AREA_BITS +: POS_BITS];

	assign s_xfer = s_tvalid && s_tready;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			turn_gain_q      <= CFG_W'(180);
			forward_gain_q   <= CFG_W'(85);
			distance_scale_q <= CFG_W'(180);
			stop_distance_q  <= THR_W'(563);
			turn_distance_q  <= THR_W'(640);
			search_base_q    <= SB_W'(60);
			search_start_q   <= SB_W'(150);
			search_decay_q   <= DEC_W'(64881);
		end else if (cfg_wr) begin
			case (cfg_reg_t'(cfg_index))
				REG_TURN_GAIN:      turn_gain_q      <= cfg_data[CFG_W-1:0];
				REG_FORWARD_GAIN:   forward_gain_q   <= cfg_data[CFG_W-1:0];
				REG_DISTANCE_SCALE: distance_scale_q <= cfg_data[CFG_W-1:0];
				REG_STOP_DISTANCE:  stop_distance_q  <= cfg_data;
				REG_TURN_DISTANCE:  turn_distance_q  <= cfg_data;
				REG_SEARCH_BASE:    search_base_q    <= cfg_data[SB_W-1:0];
				REG_SEARCH_START:   search_start_q   <= cfg_data[SB_W-1:0];
				REG_SEARCH_DECAY:   search_decay_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// serial units: distance numerator scale^2 * 2^16 over area, offset |2x-w| * 2^16 over w
	assign ds_sq    = distance_scale_q * distance_scale_q;
	assign dist_num = DIV_NW'({ds_sq, 16'd0});
	assign x2       = {in_x, 1'b0};
	assign off_mag  = (x2 >= {1'b0, in_w}) ? (x2 - {1'b0, in_w}) : ({1'b0, in_w} - x2);
	assign off_num  = DIV_NW'({off_mag, 16'd0});

	bfwsc_div u_dist_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (dist_num),
		.den    (in_area),
		.quot   (dist_quot),
		.done   (dist_done)
	);

	bfwsc_div u_off_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (off_num),
		.den    (DIV_DW'(in_w)),
		.quot   (off_quot),
		.done   (off_done)
	);

	bfwsc_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (dist_done),
		.radicand (dist_quot),
		.root     (root),
		.done     (root_done)
	);

	assign off_q_mag = off_quot[POS_BITS+16:0];

	// state machine: next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_xfer)
					state_d = (in_bump || !in_seen) ? ST_EMIT_PRE : ST_DIV;
			end
			ST_DIV:  if (off_done) state_d = ST_ROOT;
			ST_ROOT: if (root_done) state_d = ST_MULT;
			ST_MULT: state_d = ST_SUM;
			ST_SUM:  state_d = ST_EMIT_PRE;
			ST_EMIT_PRE: begin
				if (!pre_vld_q || slot_free)
					state_d = ST_EMIT_FIN;
			end
			ST_EMIT_FIN: if (slot_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// state machine: outputs
	assign slot_free = !out_vld_q || m_tready;

	always_comb begin
		s_tready  = 1'b0;
		load_pre  = 1'b0;
		load_fin  = 1'b0;
		div_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready  = 1'b1;
				div_start = s_tvalid && !in_bump && in_seen;
			end
			ST_EMIT_PRE: load_pre = pre_vld_q && slot_free;
			ST_EMIT_FIN: load_fin = slot_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// search speed decay and tracking flag
	assign ss_prod = ss_q * search_decay_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tracked_q <= 1'b0;
			ss_q      <= {SB_W'(150), 8'd0};
		end else if (s_xfer && !in_bump) begin
			if (!in_seen) begin
				tracked_q <= 1'b0;
				ss_q      <= ss_prod[SS_W+15:16];
			end else begin
				tracked_q <= 1'b1;
				if (!tracked_q)
					ss_q <= {search_start_q, 8'd0};
			end
		end
	end

	// result slots; the fixed commands are loaded at the input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pre_vld_q <= 1'b0;
		else if (s_xfer)
			pre_vld_q <= in_bump || (in_seen && !tracked_q);
	end

	always_ff @(posedge clk) begin
		if (s_xfer) begin
			if (in_bump) begin
				pre_q <= '{BACK_SPD, BACK_SPD, BACK_HOLD, tracked_q, 1'b0};
				fin_q <= '{SPIN_SPD, -SPIN_SPD, SPIN_HOLD, tracked_q, 1'b1};
			end else if (!in_seen) begin
				fin_q <= '{sat_u(SUM_W'(search_base_q) + SEARCH_EXTRA
						+ SUM_W'(ss_q[SS_W-1:8])),
						sat_u(SUM_W'(search_base_q)), '0, 1'b0, 1'b1};
			end else begin
				pre_q <= '{-REACQ_SPD, REACQ_SPD, REACQ_HOLD, 1'b1, 1'b0};
			end
			area_zero_q  <= in_area == '0;
			width_zero_q <= in_w == '0;
			off_neg_q    <= x2 < {1'b0, in_w};
		end else if (state_q == ST_SUM) begin
			fin_q <= '{l_calc, r_calc, '0, 1'b1, 1'b1};
		end
	end

	// offset and distance capture, then the two products
	always_ff @(posedge clk) begin
		if (off_done) begin
			if (width_zero_q)
				off_q <= '0;
			else if (off_neg_q)
				off_q <= -$signed({1'b0, off_q_mag});
			else
				off_q <= $signed({1'b0, off_q_mag});
		end
		if (root_done)
			d_q <= area_zero_q ? DIST_MAX : root;
		if (state_q == ST_MULT) begin
			trn_q <= off_q * $signed({1'b0, turn_gain_q});
			fwd_q <= forward_gain_q * d_q;
		end
	end

	// stop, turn in place, or drive and steer
	assign trn_e = ACC_W'(trn_q);
	assign fwd_e = $signed(ACC_W'({fwd_q, 8'd0}));

	always_comb begin
		if (d_q < DIST_W'(stop_distance_q)) begin
			l_calc = '0;
			r_calc = '0;
		end else if (d_q < DIST_W'(turn_distance_q)) begin
			l_calc = div_sat(trn_e);
			r_calc = div_sat(-trn_e);
		end else begin
			l_calc = div_sat(fwd_e + trn_e);
			r_calc = div_sat(fwd_e - trn_e);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (load_pre || load_fin)
			out_vld_q <= 1'b1;
		else if (m_tready)
			out_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_pre)
			out_q <= pre_q;
		else if (load_fin)
			out_q <= fin_q;
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = OUT_DATA_W'({out_q.hold_ms, out_q.right_speed, out_q.left_speed});
	assign m_tuser  = out_q.tracking;
	assign m_tlast  = out_q.last_of_run;

endmodule

[hdl/bfwsc_div.sv]
// ----------------------------------------------------------------------------
// bfwsc_div - bit-serial restoring divider
// one quotient bit per cycle, quotient shifts into the numerator register
// ----------------------------------------------------------------------------
module bfwsc_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [bfwsc_pkg::DIV_NW-1:0]  num,
	input  logic [bfwsc_pkg::DIV_DW-1:0]  den,
	output logic [bfwsc_pkg::DIV_NW-1:0]  quot,
	output logic                          done
);
	import bfwsc_pkg::*;

	localparam int CNT_W = $clog2(DIV_NW + 1);

	logic [DIV_NW-1:0] num_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_DW-1:0] rem_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIV_DW:0]   rem_sh;
	logic [DIV_DW:0]   rem_sub;
	logic              ge;

	assign rem_sh  = {rem_q, num_q[DIV_NW-1]};
	assign rem_sub = rem_sh - {1'b0, den_q};
	assign ge      = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DIV_NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DIV_NW-2:0], ge};
			rem_q <= ge ? rem_sub[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
		end
	end

	assign quot = num_q;
	assign done = done_q;

endmodule

[hdl/bfwsc_sqrt.sv]
// ----------------------------------------------------------------------------
// bfwsc_sqrt - digit-serial integer square root
// two radicand bits in and one root bit out per cycle
// ----------------------------------------------------------------------------
module bfwsc_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [bfwsc_pkg::SQ_W-1:0]    radicand,
	output logic [bfwsc_pkg::DIST_W-1:0]  root,
	output logic                          done
);
	import bfwsc_pkg::*;

	localparam int CNT_W = $clog2(DIST_W + 1);

	logic [SQ_W-1:0]   rad_q;
	logic [DIST_W:0]   rem_q;
	logic [DIST_W-1:0] root_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIST_W+2:0] rem_sh;
	logic [DIST_W+2:0] trial;
	logic [DIST_W+2:0] rem_sub;
	logic              ge;

	assign rem_sh  = {rem_q, rad_q[SQ_W-1:SQ_W-2]};
	assign trial   = {1'b0, root_q, 2'b01};
	assign ge      = rem_sh >= trial;
	assign rem_sub = rem_sh - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DIST_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[SQ_W-3:0], 2'b00};
			rem_q  <= ge ? rem_sub[DIST_W:0] : rem_sh[DIST_W:0];
			root_q <= {root_q[DIST_W-2:0], ge};
		end
	end

	assign root = root_q;
	assign done = done_q;

endmodule

[hdl/bfwsc_chk.sv]
// ----------------------------------------------------------------------------
// bfwsc_chk - port checker for the ball follow speed controller
// watches the stream ports and the command values
// ----------------------------------------------------------------------------
module bfwsc_chk (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_tvalid,
	input logic                                s_tready,
	input logic [bfwsc_pkg::OUT_DATA_W-1:0]    m_tdata,
	input logic                                m_tlast,
	input logic                                m_tvalid,
	input logic                                m_tready
);
	import bfwsc_pkg::*;

	logic signed [SPD_W-1:0] l_spd, r_spd;
	assign l_spd = $signed(m_tdata[SPD_W-1:0]);
	assign r_spd = $signed(m_tdata[2*SPD_W-1:SPD_W]);

	// a stalled command stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("command dropped while stalled");

	// one frame at a time
	a_one_frame: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("frame taken while another is in flight");

	// speeds stay within the wheel limit
	a_speed_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (l_spd <= SPD_LIMIT && l_spd >= -SPD_LIMIT
			&& r_spd <= SPD_LIMIT && r_spd >= -SPD_LIMIT))
		else $error("speed beyond limit");

	// the reacquire spin is never the last command of a frame
	a_reacq_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2*SPD_W +: HOLD_W] == REACQ_HOLD |-> !m_tlast)
		else $error("reacquire spin marked last");

endmodule

bind ball_follow_wheel_speed_controller bfwsc_chk u_bfwsc_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready)
);

[sim/ball_follow_wheel_speed_controller_tb.sv]
// ----------------------------------------------------------------------------
// ball_follow_wheel_speed_controller_tb - self-checking bench of the controller
// drives frame results with random gaps and output stalls, predicts the wheel
// commands in a scoreboard and compares every command field by field
// ----------------------------------------------------------------------------
module ball_follow_wheel_speed_controller_tb;

	import bfwsc_pkg::*;

	localparam int WDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 100;

	typedef struct {
		logic [SPD_W-1:0]  lspd;
		logic [SPD_W-1:0]  rspd;
		logic [HOLD_W-1:0] hold;
		logic              trk;
		logic              last;
	} wheel_cmd_t;

	// predictor of the wheel commands with its own copy of registers and state
	class wheel_cmd_board;
		longint unsigned gain_turn, gain_fwd, dscale, dstop, dturn;
		longint unsigned sbase, sstart, sdecay;
		bit tracked;
		longint unsigned sspeed;
		wheel_cmd_t pending[$];
		int errors;

		function void reset_state();
			gain_turn = 180; gain_fwd = 85; dscale = 180; dstop = 563; dturn = 640;
			sbase = 60; sstart = 150; sdecay = 64881;
			tracked = 0; sspeed = sstart << 8;
			errors = 0;
		endfunction

		function void set_reg(cfg_reg_t idx, longint unsigned v);
			case (idx)
				REG_TURN_GAIN:      gain_turn = v & 'h3FF;
				REG_FORWARD_GAIN:   gain_fwd = v & 'h3FF;
				REG_DISTANCE_SCALE: dscale = v & 'h3FF;
				REG_STOP_DISTANCE:  dstop = v & 'hFFFF;
				REG_TURN_DISTANCE:  dturn = v & 'hFFFF;
				REG_SEARCH_BASE:    sbase = v & 'h1FF;
				REG_SEARCH_START:   sstart = v & 'h1FF;
				REG_SEARCH_DECAY:   sdecay = v & 'hFFFF;
				default: ;
			endcase
		endfunction

		function longint clamp(longint v);
			if (v > 500) return 500;
			if (v < -500) return -500;
			return v;
		endfunction

		function void push(longint l, longint r, int hold, bit last);
			wheel_cmd_t c;
			c.lspd = SPD_W'(clamp(l));
			c.rspd = SPD_W'(clamp(r));
			c.hold = HOLD_W'(hold);
			c.trk = tracked;
			c.last = last;
			pending.push_back(c);
		endfunction

		function longint unsigned int_root(longint unsigned n);
			longint unsigned rt, b;
			rt = 0;
			b = 64'd1 << 62;
			while (b > n) b >>= 2;
			while (b != 0) begin
				if (n >= rt + b) begin
					n -= rt + b;
					rt = (rt >> 1) + b;
				end else
					rt >>= 1;
				b >>= 2;
			end
			return rt;
		endfunction

		// note an accepted frame result and queue the commands it causes
		function void note_frame(bit bump, bit seen, int unsigned x,
				longint unsigned area, int unsigned w);
			longint unsigned d;
			longint off, l, r, fwd, trn;
			off = 0;
			if (bump) begin
				push(-250, -250, 40, 0);
				push(200, -200, 80, 1);
				return;
			end
			if (!seen) begin
				tracked = 0;
				push(longint'(sbase) + 10 + longint'(sspeed >> 8), longint'(sbase), 0, 1);
				sspeed = ((sspeed * sdecay) >> 16) & 'h1FFFF;
				return;
			end
			if (!tracked) begin
				sspeed = (sstart << 8) & 'h1FFFF;
				tracked = 1;
				push(-150, 150, 400, 0);
			end
			if (area == 0)
				d = 'h3FFFF;
			else begin
				d = int_root((dscale * dscale * 65536) / area);
				if (d > 'h3FFFF) d = 'h3FFFF;
			end
			if (w != 0)
				off = ((longint'(x) * 2 - longint'(w)) * 65536) / longint'(w);
			if (d < dstop) begin
				l = 0; r = 0;
			end else if (d < dturn) begin
				l = (longint'(gain_turn) * off) / 65536;
				r = -l;
			end else begin
				fwd = longint'(gain_fwd * d) * 256;
				trn = longint'(gain_turn) * off;
				l = (fwd + trn) / 65536;
				r = (fwd - trn) / 65536;
			end
			push(l, r, 0, 1);
		endfunction

		// compare one accepted command with the oldest expectation
		function void check_cmd(wheel_cmd_t got);
			wheel_cmd_t exp_c;
			if (pending.size() == 0) begin
				$display("%0t: unexpected command l=%0d r=%0d", $time,
					$signed(got.lspd), $signed(got.rspd));
				errors++;
				return;
			end
			exp_c = pending.pop_front();
			if (got.lspd !== exp_c.lspd) begin
				$display("%0t: left_speed expected %0d got %0d", $time,
					$signed(exp_c.lspd), $signed(got.lspd));
				errors++;
			end
			if (got.rspd !== exp_c.rspd) begin
				$display("%0t: right_speed expected %0d got %0d", $time,
					$signed(exp_c.rspd), $signed(got.rspd));
				errors++;
			end
			if (got.hold !== exp_c.hold) begin
				$display("%0t: hold_ms expected %0d got %0d", $time, exp_c.hold, got.hold);
				errors++;
			end
			if (got.trk !== exp_c.trk) begin
				$display("%0t: tracking expected %0b got %0b", $time, exp_c.trk, got.trk);
				errors++;
			end
			if (got.last !== exp_c.last) begin
				$display("%0t: tlast expected %0b got %0b", $time, exp_c.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;
	logic                  m_tlast;
	logic                  m_tvalid;
	logic                  m_tready;
	logic                  cfg_wr;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [THR_W-1:0]      cfg_data;

	wheel_cmd_board board;
	int  idle_cycles;
	bit  long_hold;     // receiver held off for a long stretch
	bit  draining;

	ball_follow_wheel_speed_controller dut (
		.clk(clk), .arst_n(arst_n),
		.s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready),
		.cfg_wr(cfg_wr), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// mostly short gaps, now and then a long one, sometimes none at all
	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 40) return 0;
		if (p < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 80);
	endfunction

	// receiver side: random stalls, one long hold-off, checks every transfer
	initial begin
		wheel_cmd_t got;
		int stall;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got.lspd = m_tdata[SPD_W-1:0];
				got.rspd = m_tdata[2*SPD_W-1:SPD_W];
				got.hold = m_tdata[2*SPD_W+HOLD_W-1:2*SPD_W];
				got.trk = m_tuser;
				got.last = m_tlast;
				board.check_cmd(got);
			end
			if (long_hold) begin
				m_tready <= 1'b0;
				repeat (600) @(posedge clk);
				long_hold = 0;
				m_tready <= 1'b1;
			end else if (draining) begin
				m_tready <= 1'b1;
			end else begin
				stall = gap_len();
				if (stall == 0)
					m_tready <= 1'b1;
				else begin
					m_tready <= 1'b0;
					repeat (stall) @(posedge clk);
					m_tready <= 1'b1;
				end
			end
		end
	end

	// watchdog on cycles with no transfer on either side
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// offer one frame result and wait for its transfer
	task automatic send_frame(bit bump, bit seen, int unsigned x,
			longint unsigned area, int unsigned w);
		int g;
		int unsigned pos_mask;
		longint unsigned area_mask;
		pos_mask = (32'd1 << POS_BITS) - 32'd1;
		area_mask = (64'd1 << AREA_BITS) - 64'd1;
		x = x & pos_mask;
		w = w & pos_mask;
		area = area & area_mask;
		g = gap_len();
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_tdata <= IN_DATA_W'({POS_BITS'(w), AREA_BITS'(area), POS_BITS'(x), seen, bump});
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		board.note_frame(bump, seen, x, area, w);
	endtask

	task automatic write_reg(cfg_reg_t idx, int unsigned v);
		cfg_wr <= 1'b1;
		cfg_index <= idx;
		cfg_data <= THR_W'(v);
		@(posedge clk);
		cfg_wr <= 1'b0;
		board.set_reg(idx, v);
		@(posedge clk);
	endtask

	// wait for all expected commands, then let the engine settle
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// a run of frames: mostly seen balls with occasional losses and bumps
	task automatic random_frames(int n);
		int p;
		int unsigned w, x;
		longint unsigned area;
		for (int i = 0; i < n; i++) begin
			p = $urandom_range(0, 99);
			w = $urandom_range(0, 4) == 0 ? $urandom_range(0, 4095) : $urandom_range(1, 640);
			x = $urandom_range(0, 5) == 0 ? $urandom_range(0, 4095) : $urandom_range(0, w);
			case ($urandom_range(0, 4))
				0: area = $urandom_range(0, 16777215);
				1: area = $urandom_range(0, 50);
				default: area = $urandom_range(1, 60000);
			endcase
			send_frame(p < 8, p >= 8 && p < 25 ? 1'b0 : 1'b1, x, area, w);
		end
	endtask

	// register settings applied between phases, extremes among them
	task automatic apply_setting(int k);
		case (k)
			0: begin
				write_reg(REG_TURN_GAIN, 1023); write_reg(REG_FORWARD_GAIN, 1023);
				write_reg(REG_DISTANCE_SCALE, 1023); write_reg(REG_STOP_DISTANCE, 0);
				write_reg(REG_TURN_DISTANCE, 0); write_reg(REG_SEARCH_BASE, 500);
				write_reg(REG_SEARCH_START, 430); write_reg(REG_SEARCH_DECAY, 65535);
			end
			1: begin
				write_reg(REG_TURN_GAIN, 0); write_reg(REG_FORWARD_GAIN, 0);
				write_reg(REG_DISTANCE_SCALE, 0); write_reg(REG_STOP_DISTANCE, 65535);
				write_reg(REG_TURN_DISTANCE, 65535); write_reg(REG_SEARCH_BASE, 0);
				write_reg(REG_SEARCH_START, 0); write_reg(REG_SEARCH_DECAY, 0);
			end
			2: begin
				// search base beyond the speed limit saturates
				write_reg(REG_SEARCH_BASE, 511); write_reg(REG_SEARCH_START, 511);
				write_reg(REG_DISTANCE_SCALE, 300); write_reg(REG_STOP_DISTANCE, 200);
				write_reg(REG_TURN_DISTANCE, 2000);
			end
			default: begin
				write_reg(REG_TURN_GAIN, $urandom_range(0, 1023));
				write_reg(REG_FORWARD_GAIN, $urandom_range(0, 300));
				write_reg(REG_DISTANCE_SCALE, $urandom_range(0, 1023));
				write_reg(REG_STOP_DISTANCE, $urandom_range(0, 3000));
				write_reg(REG_TURN_DISTANCE, $urandom_range(0, 6000));
				write_reg(REG_SEARCH_BASE, $urandom_range(0, 511));
				write_reg(REG_SEARCH_START, $urandom_range(0, 511));
				write_reg(REG_SEARCH_DECAY, $urandom);
			end
		endcase
	endtask

	initial begin
		board = new();
		board.reset_state();
		long_hold = 0;
		draining = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_wr = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: bump, lost ball, regain, zero width, zero area, field extremes
		send_frame(1'b1, 1'b0, 0, 0, 0);
		send_frame(1'b1, 1'b1, '1, '1, '1);
		send_frame(1'b0, 1'b0, 100, 500, 640);
		send_frame(1'b0, 1'b0, 0, 0, 0);
		send_frame(1'b0, 1'b1, 320, 1000, 640);
		send_frame(1'b0, 1'b1, 320, 1000, 0);
		send_frame(1'b0, 1'b1, 100, 0, 640);
		send_frame(1'b0, 1'b1, 0, 1, 640);
		send_frame(1'b0, 1'b1, 640, 2000, 640);
		send_frame(1'b0, 1'b1, '1, '1, 1);
		send_frame(1'b0, 1'b1, 0, '1, '1);
		send_frame(1'b0, 1'b1, 300, 4000, 640);
		send_frame(1'b0, 1'b1, 500, 400, 640);
		send_frame(1'b0, 1'b0, '1, '1, '1);
		send_frame(1'b0, 1'b1, 10, 50000, 640);
		send_frame(1'b1, 1'b1, 5, 5, 5);
		send_frame(1'b0, 1'b1, 600, 6000, 640);

		// long receiver hold-off while frames keep coming
		long_hold = 1;
		random_frames(20);
		wait_idle();

		for (int k = 0; k < 7; k++) begin
			apply_setting(k);
			random_frames(k == 1 ? 120 : 230);
			wait_idle();
		end
		write_reg(REG_TURN_GAIN, 180);

		draining = 1;
		wait_idle();
		if (board.errors == 0 && board.pending.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
